// ===== hw/rtl/kwm_pkg.sv =====
// ----------------------------------------------------------------------------
// kwm_pkg - shared types and constants for the k-way merge min queue
// Field widths, operation and status codes, entry layout and control bundle.
// ----------------------------------------------------------------------------
package kwm_pkg;

	localparam int VALUE_W         = 32;
	localparam int SOURCE_W        = 4;
	localparam int STATUS_W        = 2;
	localparam int OCC_W           = 5;
	localparam int DEF_MAX_STREAMS = 16;

	// operation codes on the func field
	localparam logic FUNC_PUSH = 1'b0;
	localparam logic FUNC_POP  = 1'b1;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [SOURCE_W-1:0]       source;
	} entry_t;

	// sequencer to compare unit
	typedef struct packed {
		logic clear;
		logic update;
	} min_ctl_t;

endpackage

// ===== hw/rtl/kwm_ram.sv =====
// ----------------------------------------------------------------------------
// kwm_ram - generic single write, single read RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module kwm_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 16
) (
	input  logic                                     clk,
	input  logic                                     wr_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
	input  logic [WIDTH-1:0]                         wr_data,
	input  logic                                     rd_en,
	input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
	output logic [WIDTH-1:0]                         rd_data
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rd_data_q;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
		if (rd_en) begin
			rd_data_q <= mem_q[rd_addr];
		end
	end

	assign rd_data = rd_data_q;

endmodule

// ===== hw/rtl/kwm_min_unit.sv =====
// ----------------------------------------------------------------------------
// kwm_min_unit - shared running-minimum compare unit
// Keeps the smallest entry seen since the last clear, lower source on ties.
// ----------------------------------------------------------------------------
module kwm_min_unit import kwm_pkg::*; #(
	parameter int AW = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  min_ctl_t      ctl,
	input  entry_t        cand,
	input  logic [AW-1:0] cand_idx,
	output entry_t        best,
	output logic [AW-1:0] best_idx
);

	logic          have_q;
	entry_t        best_q;
	logic [AW-1:0] best_idx_q;
	logic          less;
	logic          take;

	// signed value first, then source index
	always_comb begin
		less = ($signed(cand.value) < $signed(best_q.value)) ||
		       ((cand.value == best_q.value) && (cand.source < best_q.source));
		take = ctl.update && (!have_q || less);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_q <= 1'b0;
		end else if (ctl.clear) begin
			have_q <= 1'b0;
		end else if (ctl.update) begin
			have_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			best_q     <= cand;
			best_idx_q <= cand_idx;
		end
	end

	assign best     = best_q;
	assign best_idx = best_idx_q;

endmodule

// ===== hw/rtl/k_way_merge_min_queue.sv =====
// ----------------------------------------------------------------------------
// k_way_merge_min_queue - min-priority store behind a k-way merge
// Holds one pending head per source stream; push inserts, pop takes minimum.
// ----------------------------------------------------------------------------
// Usage
//   Request channel (req_valid / req_stall): func selects push (value, source)
//   or pop. A request is taken when req_valid is high and req_stall low.
//   Result channel (res_valid / res_stall): exactly one result per request,
//   held in an output register until taken.
//   Entries sit unsorted in a RAM. A push writes the next free slot. A pop
//   reads every held entry through one compare unit that tracks the minimum
//   (lower source wins a tie), then moves the last entry into the hole.
//   Sequence: a push or an error passes through S_RESP into the output register,
//   after which the next request can be taken; a pop passes through S_SCAN,
//   S_FILL and S_RESP, the scan paced by the single RAM read port feeding the
//   compare unit one entry per cycle. req_stall is high from the taking edge
//   until the result enters the output register.
//   A new request is taken while the previous result still waits in the
//   output register; if that register is still stalled when the next result
//   is ready, the block waits and keeps req_stall high.
//   Reset empties the store (count to zero) and drops any pending result.
//   RAM contents are not cleared: only slots below the count are ever read.
// ----------------------------------------------------------------------------
module k_way_merge_min_queue import kwm_pkg::*; #(
	parameter int MAX_STREAMS = DEF_MAX_STREAMS
) (
	input  logic                       clk,
	input  logic                       arst_n,
	// request channel
	input  logic                       req_valid,
	output logic                       req_stall,
	input  logic                       func,
	input  logic signed [VALUE_W-1:0]  value,
	input  logic [SOURCE_W-1:0]        source,
	// result channel
	output logic                       res_valid,
	input  logic                       res_stall,
	output logic                       out_valid,
	output logic signed [VALUE_W-1:0]  out_value,
	output logic [SOURCE_W-1:0]        out_source,
	output logic [STATUS_W-1:0]        status,
	output logic [OCC_W-1:0]           occupancy
);

	localparam int AW      = (MAX_STREAMS > 1) ? $clog2(MAX_STREAMS) : 1;
	localparam int CW      = $clog2(MAX_STREAMS + 1);
	localparam int ENTRY_W = $bits(entry_t);

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_FILL,
		S_RESP
	} state_t;

	state_t        state_q;
	logic [CW-1:0] cnt_q;      // entries held
	logic [CW-1:0] iss_q;      // next scan address
	logic          pend_s1;    // read data valid this cycle
	logic [AW-1:0] idx_s1;     // address of that data
	entry_t        last_q;     // last held entry, refills the hole

	// result waiting for the output register
	logic                      r_valid_q;
	logic signed [VALUE_W-1:0] r_value_q;
	logic [SOURCE_W-1:0]       r_source_q;
	status_t                   r_status_q;

	// output register
	logic                      res_valid_q;
	logic                      out_valid_q;
	logic signed [VALUE_W-1:0] out_value_q;
	logic [SOURCE_W-1:0]       out_source_q;
	logic [STATUS_W-1:0]       status_q;
	logic [OCC_W-1:0]          occupancy_q;

	logic               req_accept;
	logic               out_free;
	logic               full;
	logic               empty;
	logic               is_last;
	logic               wr_en;
	logic [AW-1:0]      wr_addr;
	logic [ENTRY_W-1:0] wr_data;
	logic               rd_en;
	logic [ENTRY_W-1:0] rd_data;
	entry_t             rd_entry;
	entry_t             push_entry;
	min_ctl_t           min_ctl;
	entry_t             best;
	logic [AW-1:0]      best_idx;

	assign req_stall  = (state_q != S_IDLE);
	assign req_accept = req_valid && (state_q == S_IDLE);
	assign out_free   = !res_valid_q || !res_stall;
	assign full       = (cnt_q == CW'(MAX_STREAMS));
	assign empty      = (cnt_q == '0);
	assign is_last    = (CW'(idx_s1) == CW'(cnt_q - CW'(1)));

	assign push_entry.value  = value;
	assign push_entry.source = source;
	assign rd_entry          = entry_t'(rd_data);

	// write: a push into the next free slot, or the hole refill after a pop
	always_comb begin
		wr_en   = (req_accept && (func == FUNC_PUSH) && !full) || (state_q == S_FILL);
		wr_addr = (state_q == S_FILL) ? best_idx : cnt_q[AW-1:0];
		wr_data = (state_q == S_FILL) ? last_q : push_entry;
		rd_en   = (state_q == S_SCAN) && (iss_q < cnt_q);
	end

	assign min_ctl.clear  = req_accept;
	assign min_ctl.update = pend_s1;

	kwm_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (MAX_STREAMS)
	) u_ram (
		.clk     (clk),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.rd_en   (rd_en),
		.rd_addr (iss_q[AW-1:0]),
		.rd_data (rd_data)
	);

	kwm_min_unit #(
		.AW (AW)
	) u_min (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (min_ctl),
		.cand     (rd_entry),
		.cand_idx (idx_s1),
		.best     (best),
		.best_idx (best_idx)
	);

	// sequencer and registered outputs
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			cnt_q        <= '0;
			iss_q        <= '0;
			pend_s1      <= 1'b0;
			idx_s1       <= '0;
			last_q       <= '0;
			r_valid_q    <= 1'b0;
			r_value_q    <= '0;
			r_source_q   <= '0;
			r_status_q   <= ST_OK;
			res_valid_q  <= 1'b0;
			out_valid_q  <= 1'b0;
			out_value_q  <= '0;
			out_source_q <= '0;
			status_q     <= ST_OK;
			occupancy_q  <= '0;
		end else begin
			// load a new result, or drop the taken one
			if ((state_q == S_RESP) && out_free) begin
				res_valid_q <= 1'b1;
			end else if (!res_stall) begin
				res_valid_q <= 1'b0;
			end

			case (state_q)
				S_IDLE: begin
					if (req_valid) begin
						r_valid_q  <= 1'b0;
						r_value_q  <= '0;
						r_source_q <= '0;
						if (func == FUNC_POP) begin
							if (empty) begin
								r_status_q <= ST_EMPTY;
								state_q    <= S_RESP;
							end else begin
								iss_q   <= '0;
								pend_s1 <= 1'b0;
								state_q <= S_SCAN;
							end
						end else begin
							if (full) begin
								r_status_q <= ST_FULL;
							end else begin
								r_status_q <= ST_OK;
								cnt_q      <= cnt_q + CW'(1);
							end
							state_q <= S_RESP;
						end
					end
				end

				S_SCAN: begin
					pend_s1 <= rd_en;
					idx_s1  <= iss_q[AW-1:0];
					if (rd_en) begin
						iss_q <= iss_q + CW'(1);
					end
					if (pend_s1 && is_last) begin
						last_q  <= rd_entry;
						state_q <= S_FILL;
					end
				end

				S_FILL: begin
					// minimum is final; its slot takes the last entry this cycle
					pend_s1    <= 1'b0;
					r_valid_q  <= 1'b1;
					r_value_q  <= best.value;
					r_source_q <= best.source;
					r_status_q <= ST_OK;
					cnt_q      <= cnt_q - CW'(1);
					state_q    <= S_RESP;
				end

				S_RESP: begin
					if (out_free) begin
						out_valid_q  <= r_valid_q;
						out_value_q  <= r_value_q;
						out_source_q <= r_source_q;
						status_q     <= r_status_q;
						occupancy_q  <= OCC_W'(cnt_q);
						state_q      <= S_IDLE;
					end
				end

				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	assign res_valid  = res_valid_q;
	assign out_valid  = out_valid_q;
	assign out_value  = out_value_q;
	assign out_source = out_source_q;
	assign status     = status_q;
	assign occupancy  = occupancy_q;

	// ------------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------------

	// never more entries than slots
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(MAX_STREAMS))
		else $error("entry count beyond capacity");

	// count moves by at most one per cycle
	a_cnt_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (cnt_q == $past(cnt_q)) || (cnt_q == $past(cnt_q) + CW'(1)) ||
		         (cnt_q + CW'(1) == $past(cnt_q)))
		else $error("entry count jumped");

	// the refilled slot lies inside the held range
	a_fill_idx: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_FILL) |-> (CW'(best_idx) < cnt_q))
		else $error("minimum slot outside held entries");

	// a returned entry always carries ok status
	a_pop_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid_q && out_valid_q) |-> (status_q == ST_OK))
		else $error("returned entry with error status");

endmodule
